// ===== sv/dlpg_pkg.sv =====
package dlpg_pkg;

    localparam int TILE_SIZE = 64;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = $clog2(TILE_SIZE);
    localparam int ACC_W     = COORD_W + FRAC_BITS;
    localparam int SLOPE_W   = FRAC_BITS + 1;
    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int ADDR_W    = 12;
    localparam int PITCH_W   = 7;
    localparam int COLOR_W   = 32;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);

    // saturate a coordinate to the tile
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [5:0] v);
        logic [COORD_W-1:0] c;
        if (COORD_W'(v) > COORD_MAX || {26'd0, v} > 32'(TILE_SIZE - 1))
        begin
            c = COORD_MAX;
        end
        else
        begin
            c = COORD_W'(v);
        end
        return c;
    endfunction

    typedef struct packed {
        logic start;
        logic [COORD_W-1:0] dividend_mag;
        logic [COORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [SLOPE_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/dlpg_div.sv =====
module dlpg_div
    import dlpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // restoring divider, one quotient bit per cycle
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [ACC_W-1:0]     quot_reg, quot_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0]   divisor_reg, divisor_next;
    logic [COORD_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, quot_reg[ACC_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(DIV_STEPS);
            quot_next    = {req.dividend_mag, {FRAC_BITS{1'b0}}};
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = COORD_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = COORD_W'(trial);
            end
            quot_next  = {quot_reg[ACC_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg[SLOPE_W-1:0];

endmodule

// ===== sv/dda_line_pixel_generator_unit.sv =====
// DDA line pixel generator.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; it carries start_x/start_y, end_x/end_y and line_color. busy stays
// high while the line is worked on, so one line is handled at a time.
// Result channel: one framebuffer write per pixel, shown for exactly one cycle
// with pixel_valid high; last_pixel marks the final write of the line. The start
// pixel is drawn, the end pixel is not, and a zero-length line gives nothing.
// Timing: the slope |minor|*2^16/|major| comes from a restoring divider, one
// quotient bit per cycle. A command transaction starts the divider; its result
// moves the sequencer to drawing, one pixel per cycle. The next command is
// taken once busy is low again. A zero-length line never raises busy.
// Configuration: APB port, row_pitch at byte address 0. The user writes it
// only while the block is idle; the block does not enforce this. pready is
// always high. Reset (rst_n low, asynchronous) sets row_pitch to 64 and
// drops busy and pixel_valid.
// The receiver cannot stall: every write must be taken in the cycle it shows.
module dda_line_pixel_generator_unit
    import dlpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         start_x,
    input  logic [5:0]         start_y,
    input  logic [5:0]         end_x,
    input  logic [5:0]         end_y,
    input  logic [COLOR_W-1:0] line_color,
    output logic               pixel_valid,
    output logic [ADDR_W-1:0]  pixel_address,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               last_pixel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DRAW = 2'd2;

    localparam logic ADDR_ROW_PITCH = 1'b0;
    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(64);

    // config register
    logic [PITCH_W-1:0] row_pitch_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ADDR_ROW_PITCH) ? {25'd0, row_pitch_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pitch_reg <= PITCH_RESET;
        end
        else if (cfg_write && paddr[2] == ADDR_ROW_PITCH)
        begin
            row_pitch_reg <= pwdata[PITCH_W-1:0];
        end
    end

    // command decode: deltas, major axis, directions
    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic [COORD_W-1:0] adx, ady;
    logic               major_x;
    logic [COORD_W-1:0] steps_in, min_mag_in;
    logic               accept;

    assign sx = clamp_coord(start_x);
    assign sy = clamp_coord(start_y);
    assign ex = clamp_coord(end_x);
    assign ey = clamp_coord(end_y);

    assign adx        = (ex >= sx) ? ex - sx : sx - ex;
    assign ady        = (ey >= sy) ? ey - sy : sy - ey;
    assign major_x    = !(ady > adx);
    assign steps_in   = major_x ? adx : ady;
    assign min_mag_in = major_x ? ady : adx;
    assign accept     = start && !busy;

    // divider for the slope
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign div_req.start        = accept && (steps_in != '0);
    assign div_req.dividend_mag = min_mag_in;
    assign div_req.divisor      = steps_in;

    dlpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and stepping state
    logic [1:0]         state_reg, state_next;
    logic [COORD_W-1:0] steps_left_reg, steps_left_next;
    logic               pix_valid_reg, pix_valid_next;

    logic               major_x_reg;
    logic               maj_up_reg, min_up_reg;
    logic [COORD_W-1:0] maj_reg, maj_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SLOPE_W-1:0] slope_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic               last_reg;

    logic [COORD_W-1:0]         minor, col, row;
    logic [COORD_W+PITCH_W-1:0] row_off;
    logic [ADDR_W-1:0]          addr_calc;

    assign minor     = acc_reg[ACC_W-1:FRAC_BITS];
    assign col       = major_x_reg ? maj_reg : minor;
    assign row       = major_x_reg ? minor : maj_reg;
    assign row_off   = row * row_pitch_reg;
    assign addr_calc = ADDR_W'(col) + row_off[ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        steps_left_next = steps_left_reg;
        pix_valid_next  = 1'b0;
        maj_next        = maj_reg;
        acc_next        = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_req.start)
                begin
                    state_next      = ST_DIV;
                    steps_left_next = steps_in;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                pix_valid_next  = 1'b1;
                steps_left_next = steps_left_reg - 1'b1;
                maj_next        = maj_up_reg ? maj_reg + 1'b1 : maj_reg - 1'b1;
                acc_next        = min_up_reg ? acc_reg + ACC_W'(slope_reg)
                                             : acc_reg - ACC_W'(slope_reg);
                if (steps_left_reg == COORD_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            steps_left_reg <= '0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            pix_valid_reg  <= pix_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            major_x_reg <= major_x;
            maj_up_reg  <= major_x ? (ex >= sx) : (ey >= sy);
            min_up_reg  <= major_x ? (ey >= sy) : (ex >= sx);
            maj_reg     <= major_x ? sx : sy;
            acc_reg     <= {(major_x ? sy : sx), {FRAC_BITS{1'b0}}};
            color_reg   <= line_color;
        end
        else
        begin
            maj_reg <= maj_next;
            acc_reg <= acc_next;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            slope_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_DRAW)
        begin
            addr_reg <= addr_calc;
            last_reg <= (steps_left_reg == COORD_W'(1));
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign pixel_valid   = pix_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_color   = color_reg;
    assign last_pixel    = pix_valid_reg && last_reg;

`ifndef NO_ASSERTIONS
    // a pixel only follows a drawing cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> $past(state_reg == ST_DRAW))
        else $error("pixel strobe without drawing cycle");

    // drawing never runs with no steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (steps_left_reg != '0))
        else $error("drawing with zero steps left");

    // the slope arrives only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide phase");

    // after the last pixel the block is free
    assert property (@(posedge clk) disable iff (!rst_n)
        last_pixel |-> (state_reg != ST_DRAW))
        else $error("still drawing after last pixel");
`endif

endmodule

// ===== tb/dlpg_line_checker.sv =====
// Watches the command, pixel and APB channels of the DDA line unit, keeps
// its own copy of row_pitch and predicts every pixel write of each line.
module dlpg_line_checker
    import dlpg_pkg::*;
#(
    parameter logic [2:0] PITCH_ADDR = 3'd0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [5:0]         start_x,
    input  logic [5:0]         start_y,
    input  logic [5:0]         end_x,
    input  logic [5:0]         end_y,
    input  logic [COLOR_W-1:0] line_color,
    input  logic               pixel_valid,
    input  logic [ADDR_W-1:0]  pixel_address,
    input  logic [COLOR_W-1:0] pixel_color,
    input  logic               last_pixel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 failures,
    output int                 pending,
    output int                 lines_seen,
    output int                 pixels_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_write_t;

    pixel_write_t       expected_writes[$];
    logic [PITCH_W-1:0] pitch_copy;

    initial
    begin
        failures    = 0;
        pending     = 0;
        lines_seen  = 0;
        pixels_seen = 0;
        pitch_copy  = PITCH_W'(64);
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic int unsigned tile_sat(input logic [5:0] v);
        int unsigned c;
        c = v;
        if (c > TILE_SIZE - 1)
        begin
            c = TILE_SIZE - 1;
        end
        return c;
    endfunction

    // Walk the line with the Q6.16 minor accumulator, one write per step.
    function automatic void rasterize_line(input logic [5:0] sx_in, input logic [5:0] sy_in,
                                           input logic [5:0] ex_in, input logic [5:0] ey_in,
                                           input logic [COLOR_W-1:0] color);
        int unsigned sx, sy, ex, ey, adx, ady;
        int unsigned steps, mag, maj, maj_end, min_beg, min_end;
        int unsigned slope, acc, minor, col, row;
        bit x_major, maj_up, min_up;
        pixel_write_t w;
        sx  = tile_sat(sx_in);
        sy  = tile_sat(sy_in);
        ex  = tile_sat(ex_in);
        ey  = tile_sat(ey_in);
        adx = (ex >= sx) ? ex - sx : sx - ex;
        ady = (ey >= sy) ? ey - sy : sy - ey;
        x_major = !(ady > adx);    // tie goes to x
        maj     = x_major ? sx : sy;
        maj_end = x_major ? ex : ey;
        min_beg = x_major ? sy : sx;
        min_end = x_major ? ey : ex;
        steps   = x_major ? adx : ady;
        mag     = x_major ? ady : adx;
        maj_up  = maj_end >= maj;
        min_up  = min_end >= min_beg;
        if (steps == 0)
        begin
            return;
        end
        slope = (mag << FRAC_BITS) / steps;
        acc   = min_beg << FRAC_BITS;
        for (int unsigned i = 0; i < steps; i++)
        begin
            minor   = acc >> FRAC_BITS;
            col     = x_major ? maj : minor;
            row     = x_major ? minor : maj;
            w.addr  = ADDR_W'(col + row * pitch_copy);
            w.color = color;
            w.last  = (i + 1 == steps);
            expected_writes.push_back(w);
            acc = min_up ? acc + slope : acc - slope;
            maj = maj_up ? maj + 1 : maj - 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_writes.delete();
            pitch_copy = PITCH_W'(64);
        end
        else
        begin
            if (psel && penable && pready && paddr == PITCH_ADDR)
            begin
                if (pwrite)
                begin
                    pitch_copy = pwdata[PITCH_W-1:0];
                end
                else if (prdata != 32'(pitch_copy))
                begin
                    note_failure($sformatf("row_pitch readback expected %0d got %0d",
                                           pitch_copy, prdata));
                end
            end
            if (start && !busy)
            begin
                lines_seen++;
                rasterize_line(start_x, start_y, end_x, end_y, line_color);
            end
            if (pixel_valid)
            begin
                pixel_write_t want;
                pixels_seen++;
                if (expected_writes.size() == 0)
                begin
                    note_failure($sformatf("unexpected pixel write addr %0h color %0h last %0b",
                                           pixel_address, pixel_color, last_pixel));
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (pixel_address != want.addr)
                    begin
                        note_failure($sformatf("pixel_address expected %0h got %0h",
                                               want.addr, pixel_address));
                    end
                    if (pixel_color != want.color)
                    begin
                        note_failure($sformatf("pixel_color expected %0h got %0h",
                                               want.color, pixel_color));
                    end
                    if (last_pixel != want.last)
                    begin
                        note_failure($sformatf("last_pixel expected %0b got %0b",
                                               want.last, last_pixel));
                    end
                end
            end
        end
        pending = expected_writes.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the DDA line unit bench: clock, reset, line commands and APB writes.
// All checking lives in dlpg_line_checker; this module only drives and judges.
module tb
    import dlpg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ROW_PITCH_ADDR = 3'd0;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         SETTLE_CYCLES  = 30;     // quiet gap before the APB write
    localparam int         END_CYCLES     = 100;
    localparam int         LINES_PER_SET  = 42;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [5:0]         start_x = '0;
    logic [5:0]         start_y = '0;
    logic [5:0]         end_x = '0;
    logic [5:0]         end_y = '0;
    logic [COLOR_W-1:0] line_color = '0;
    logic               pixel_valid;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int failures, pending, lines_seen, pixels_seen;
    int cycles = 0;
    int sender_idle_pct = 37;   // chance per cycle that the sender holds off
    int pitch_writes = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    dda_line_pixel_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .pixel_valid   (pixel_valid),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dlpg_line_checker #(.PITCH_ADDR(ROW_PITCH_ADDR)) line_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_color    (line_color),
        .pixel_valid   (pixel_valid),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .failures      (failures),
        .pending       (pending),
        .lines_seen    (lines_seen),
        .pixels_seen   (pixels_seen)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("watchdog expired after %0d cycles, %0d writes outstanding",
                     cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    // One line command transaction. start stays high after acceptance so the
    // next command can follow back to back; an idle gap lowers it first.
    task automatic send_line(input logic [5:0] sx, input logic [5:0] sy,
                             input logic [5:0] ex, input logic [5:0] ey,
                             input logic [COLOR_W-1:0] color);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            // sometimes let the block go idle first so gaps also land after busy
            if ($urandom_range(0, 1) == 1)
            begin
                while (busy)
                begin
                    @(posedge clk);
                end
            end
            while ($urandom_range(0, 99) < sender_idle_pct)
            begin
                @(posedge clk);
            end
        end
        start      <= 1'b1;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        line_color <= color;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    function automatic logic [5:0] to_tile(input int v);
        if (v < 0)
        begin
            return 6'd0;
        end
        if (v > TILE_SIZE - 1)
        begin
            return 6'(TILE_SIZE - 1);
        end
        return 6'(v);
    endfunction

    // Mostly short and random lines, with axis-aligned, diagonal and
    // zero-length ones mixed in.
    task automatic send_random_line();
        int sx, sy, ex, ey, d, kind;
        sx   = $urandom_range(0, 63);
        sy   = $urandom_range(0, 63);
        kind = $urandom_range(0, 19);
        d    = $urandom_range(1, 63);
        if (kind == 0)
        begin
            ex = sx;
            ey = sy;
        end
        else if (kind == 1)
        begin
            ex = $urandom_range(0, 63);
            ey = sy;
        end
        else if (kind == 2)
        begin
            ex = sx;
            ey = $urandom_range(0, 63);
        end
        else if (kind <= 4)
        begin
            ex = $urandom_range(0, 1) ? sx + d : sx - d;
            ey = $urandom_range(0, 1) ? sy + d : sy - d;
        end
        else if (kind <= 10)
        begin
            ex = sx + $urandom_range(0, 16) - 8;
            ey = sy + $urandom_range(0, 16) - 8;
        end
        else
        begin
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 63);
        end
        send_line(6'(sx), 6'(sy), to_tile(ex), to_tile(ey), $urandom());
    endtask

    // Pause until every predicted write has come and the block is idle,
    // then leave a quiet gap.
    task automatic wait_drained();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write row_pitch, then read it back; psel stays high across both.
    task automatic set_row_pitch(input logic [PITCH_W-1:0] pitch);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROW_PITCH_ADDR;
        pwdata  <= {25'($urandom_range(0, 2 ** 25 - 1)), pitch};   // upper bits are noise
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pitch_writes++;
    endtask

    initial
    begin
        logic [PITCH_W-1:0] pitch_plan [6];
        pitch_plan = '{7'd1, 7'd127, 7'd0, 7'(64), 7'd0, 7'd0};
        pitch_plan[4] = PITCH_W'($urandom_range(1, 64));
        pitch_plan[5] = PITCH_W'($urandom_range(0, 127));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset pitch: full-length spans in all four
        // directions, all four diagonals (tie -> x major), zero-length lines,
        // single pixels, shallow and steep slopes, rising and falling minor axis.
        send_line(6'd0,  6'd0,  6'd63, 6'd0,  32'h0000_0000);
        send_line(6'd63, 6'd0,  6'd0,  6'd0,  32'hFFFF_FFFF);
        send_line(6'd0,  6'd0,  6'd0,  6'd63, 32'hAAAA_AAAA);
        send_line(6'd0,  6'd63, 6'd0,  6'd0,  32'h5555_5555);
        send_line(6'd0,  6'd0,  6'd63, 6'd63, 32'h0123_4567);
        send_line(6'd63, 6'd63, 6'd0,  6'd0,  32'h89AB_CDEF);
        send_line(6'd63, 6'd0,  6'd0,  6'd63, 32'hFFFF_0000);
        send_line(6'd0,  6'd63, 6'd63, 6'd0,  32'h0000_FFFF);
        send_line(6'd10, 6'd10, 6'd10, 6'd10, 32'hDEAD_BEEF);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_line(6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000);
        send_line(6'd0,  6'd40, 6'd63, 6'd0,  32'h8000_0001);
        send_line(6'd5,  6'd0,  6'd12, 6'd63, 32'h7FFF_FFFE);
        send_line(6'd40, 6'd3,  6'd0,  6'd20, 32'hC3C3_C3C3);
        send_line(6'd1,  6'd1,  6'd2,  6'd1,  32'h3C3C_3C3C);
        send_line(6'd1,  6'd1,  6'd2,  6'd2,  32'h0F0F_0F0F);
        send_line(6'd30, 6'd30, 6'd29, 6'd31, 32'hF0F0_F0F0);
        send_line(6'd0,  6'd0,  6'd63, 6'd1,  32'h1111_1111);
        send_line(6'd63, 6'd62, 6'd0,  6'd63, 32'hEEEE_EEEE);
        send_line(6'd0,  6'd0,  6'd3,  6'd62, 32'h2468_ACE0);

        // Random phases, each at its own row pitch (extremes first); the
        // sender idles 37% of cycles, then 57%, then not at all.
        for (int phase = 0; phase < 6; phase++)
        begin
            sender_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 57 : 0;
            wait_drained();
            set_row_pitch(pitch_plan[phase]);
            repeat (LINES_PER_SET) send_random_line();
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d line commands and %0d pixel writes over %0d row pitch settings",
                 lines_seen, pixels_seen, pitch_writes + 1);
        $display("pitches 0, 1, 64 and 127 included; sender idle rates 37%%, 57%% and none");
        if (failures == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
